FILE: design/swept_box_reservation_table_defines.svh
// Shared assertion macros for the reservation table checks.
`ifndef SWEPT_BOX_RESERVATION_TABLE_DEFINES_SVH
`define SWEPT_BOX_RESERVATION_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SBRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbrt check failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define SBRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbrt check failed");

`endif

FILE: design/sbrt_pkg.sv
package sbrt_pkg;

    // Request kinds carried on s_axis_tuser
    localparam logic REQ_RESERVE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        OUT_GRANTED  = 2'd0,
        OUT_OVERLAP  = 2'd1,
        OUT_FULL     = 2'd2,
        OUT_RELEASED = 2'd3
    } outcome_t;

    // Per-cell command from the table control
    typedef struct packed {
        logic alloc;    // store query box if this cell is the lowest free one
        logic clear;    // mark this cell free
    } cell_ctrl_t;

    // Per-cell status back to the table control
    typedef struct packed {
        logic hit;      // used and strictly overlapping the query box
        logic take;     // lowest free cell in the chain
    } cell_stat_t;

endpackage

FILE: design/sbrt_cell.sv
module sbrt_cell #(
    parameter int BOUND_W = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbrt_pkg::cell_ctrl_t          ctrl,
    input  logic [2:0][BOUND_W-1:0]       q_lo,
    input  logic [2:0][BOUND_W-1:0]       q_hi,
    input  logic                          grant_in,
    output logic                          grant_out,
    output sbrt_pkg::cell_stat_t          stat
);

    logic                    used_reg;
    logic [2:0][BOUND_W-1:0] lo_reg;
    logic [2:0][BOUND_W-1:0] hi_reg;
    logic [2:0]              axis_ovl;
    logic                    take;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            axis_ovl[a] = ($signed(hi_reg[a]) > $signed(q_lo[a])) &&
                          ($signed(q_hi[a]) > $signed(lo_reg[a]));
        end
    end

    // grant_in high means no free cell below this one
    assign take      = grant_in && !used_reg;
    assign grant_out = grant_in && used_reg;
    assign stat.hit  = used_reg && (&axis_ovl);
    assign stat.take = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.alloc && take) begin
            used_reg <= 1'b1;
        end else if (ctrl.clear) begin
            used_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.alloc && take) begin
            lo_reg <= q_lo;
            hi_reg <= q_hi;
        end
    end

endmodule

FILE: design/swept_box_reservation_table.sv
// A request is registered on accept (query box built ahead of the accept edge); the table
// decides from those registers into the output register. One request is in flight at a time:
// s_axis_tready stays low until its result commits. All cells compare in parallel in the
// decide cycle, and the free-slot search ripples through the cell chain in that same cycle.
// A result stalled on m_axis_tready holds the decide cycle until it drains.
// Reset (aresetn low, synchronous) frees every slot and empties the output register.
module swept_box_reservation_table #(
    parameter int TABLE_SLOTS = 16,
    parameter int COORD_BITS  = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, margin, release_slot
    input  logic [((7*COORD_BITS-1+$clog2(TABLE_SLOTS+1)+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // slot_number
    output logic [(($clog2(TABLE_SLOTS+1)+7)/8)*8-1:0] m_axis_tdata,
    // outcome
    output logic [1:0]             m_axis_tuser
);

    localparam int SLOT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int BOUND_W    = COORD_BITS + 1;
    localparam int MARGIN_W   = COORD_BITS - 1;
    localparam int OUT_DATA_W = ((SLOT_W + 7) / 8) * 8;
    localparam int MARGIN_OFS = 6 * COORD_BITS;
    localparam int SLOT_OFS   = 7 * COORD_BITS - 1;

    logic [2:0][BOUND_W-1:0] span_lo;
    logic [2:0][BOUND_W-1:0] span_hi;
    logic [BOUND_W-1:0]      margin_ext;

    logic [2:0][BOUND_W-1:0] q_lo_reg;
    logic [2:0][BOUND_W-1:0] q_hi_reg;
    logic                    req_type_reg;
    logic [SLOT_W-1:0]       rel_slot_reg;
    logic                    busy_reg;
    logic                    m_valid_reg;
    logic [SLOT_W-1:0]       m_slot_reg;
    sbrt_pkg::outcome_t      m_outcome_reg;

    logic                    commit;
    logic                    do_reserve;
    logic [TABLE_SLOTS:0]    grant;
    sbrt_pkg::cell_ctrl_t    cell_ctrl [TABLE_SLOTS];
    sbrt_pkg::cell_stat_t    cell_stat [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]  hit_vec;
    logic [TABLE_SLOTS-1:0]  rel_vec;
    logic [SLOT_W-1:0]       take_slot;
    logic                    any_hit;
    logic                    table_full;
    logic [SLOT_W-1:0]       res_slot;
    sbrt_pkg::outcome_t      res_outcome;

    // Query box per axis: min - margin to max + margin, exact in BOUND_W bits
    assign margin_ext = BOUND_W'(s_axis_tdata[MARGIN_OFS +: MARGIN_W]);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [BOUND_W-1:0] pa;
            logic [BOUND_W-1:0] pb;
            pa = BOUND_W'($signed(s_axis_tdata[a*COORD_BITS +: COORD_BITS]));
            pb = BOUND_W'($signed(s_axis_tdata[(a+3)*COORD_BITS +: COORD_BITS]));
            if ($signed(pa) <= $signed(pb)) begin
                span_lo[a] = pa - margin_ext;
                span_hi[a] = pb + margin_ext;
            end else begin
                span_lo[a] = pb - margin_ext;
                span_hi[a] = pa + margin_ext;
            end
        end
    end

    assign s_axis_tready = !busy_reg;
    assign commit        = busy_reg && (!m_valid_reg || m_axis_tready);
    assign do_reserve    = commit && (req_type_reg == sbrt_pkg::REQ_RESERVE);

    assign grant[0] = 1'b1;

    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        assign rel_vec[i] = (rel_slot_reg == SLOT_W'(i + 1));
        assign cell_ctrl[i].alloc = do_reserve && !any_hit;
        assign cell_ctrl[i].clear = commit && (req_type_reg == sbrt_pkg::REQ_RELEASE) &&
                                    rel_vec[i];
        assign hit_vec[i] = cell_stat[i].hit;

        sbrt_cell #(
            .BOUND_W (BOUND_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl[i]),
            .q_lo      (q_lo_reg),
            .q_hi      (q_hi_reg),
            .grant_in  (grant[i]),
            .grant_out (grant[i+1]),
            .stat      (cell_stat[i])
        );
    end

    assign any_hit    = |hit_vec;
    assign table_full = grant[TABLE_SLOTS];

    // take is one-hot (or zero), so an OR of tagged indexes encodes it
    always_comb begin
        take_slot = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (cell_stat[i].take) begin
                take_slot = take_slot | SLOT_W'(i + 1);
            end
        end
    end

    always_comb begin
        if (req_type_reg == sbrt_pkg::REQ_RELEASE) begin
            res_slot    = (|rel_vec) ? rel_slot_reg : '0;
            res_outcome = sbrt_pkg::OUT_RELEASED;
        end else if (any_hit) begin
            res_slot    = '0;
            res_outcome = sbrt_pkg::OUT_OVERLAP;
        end else if (table_full) begin
            res_slot    = '0;
            res_outcome = sbrt_pkg::OUT_FULL;
        end else begin
            res_slot    = take_slot;
            res_outcome = sbrt_pkg::OUT_GRANTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                busy_reg <= 1'b1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            q_lo_reg     <= span_lo;
            q_hi_reg     <= span_hi;
            req_type_reg <= s_axis_tuser;
            rel_slot_reg <= s_axis_tdata[SLOT_OFS +: SLOT_W];
        end
        if (commit) begin
            m_slot_reg    <= res_slot;
            m_outcome_reg <= res_outcome;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_slot_reg);
    assign m_axis_tuser  = m_outcome_reg;

endmodule

FILE: design/sbrt_checker.sv
`include "swept_box_reservation_table_defines.svh"

module sbrt_checker #(
    parameter int TABLE_SLOTS = 16,
    parameter int COORD_BITS  = 24
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [(($clog2(TABLE_SLOTS+1)+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int COORD_W = COORD_BITS;

    logic [SLOT_W-1:0] slot;
    logic              granted;
    logic              refused;
    logic              s_fire;

    assign slot    = m_axis_tdata[SLOT_W-1:0];
    assign granted = (m_axis_tuser == sbrt_pkg::OUT_GRANTED);
    assign refused = (m_axis_tuser == sbrt_pkg::OUT_OVERLAP) ||
                     (m_axis_tuser == sbrt_pkg::OUT_FULL);
    assign s_fire  = s_axis_tvalid && s_axis_tready && (COORD_W > 0) &&
                     ((s_axis_tuser == sbrt_pkg::REQ_RESERVE) ||
                      (s_axis_tuser == sbrt_pkg::REQ_RELEASE));

    `SBRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `SBRT_ASSERT_NEXT(a_one_in_flight, s_fire, !s_axis_tready)
    `SBRT_ASSERT_NOW(a_grant_slot, m_axis_tvalid && granted,
        (slot != '0) && (slot <= SLOT_W'(TABLE_SLOTS)))
    `SBRT_ASSERT_NOW(a_refuse_slot, m_axis_tvalid && refused, slot == '0)

endmodule

bind swept_box_reservation_table sbrt_checker #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COORD_BITS  (COORD_BITS)
) u_sbrt_checker (.*);

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbrt_pkg::*;

    localparam int SLOTS    = 16;
    localparam int COORD_W  = 24;
    localparam int SLOT_W   = $clog2(SLOTS + 1);
    localparam int REQ_W    = 7 * COORD_W - 1 + SLOT_W;
    localparam int TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SLOT_W + 7) / 8) * 8;
    localparam int N_RANDOM = 1200;

    typedef struct packed {
        logic                      kind;
        logic [2:0][COORD_W-1:0]   first_pt;   // [0] x, [1] y, [2] z
        logic [2:0][COORD_W-1:0]   second_pt;
        logic [COORD_W-2:0]        margin;
        logic [SLOT_W-1:0]         rel_slot;
    } box_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        outcome_t          outcome;
    } slot_outcome_t;

    typedef struct {
        box_req_t      req;
        bit            known;
        slot_outcome_t want;
    } table_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    // shadow of the reservation table; free after reset
    bit                       occupied [SLOTS];
    logic signed [COORD_W:0]  lo_bound [SLOTS][3];
    logic signed [COORD_W:0]  hi_bound [SLOTS][3];

    slot_outcome_t pending_outcomes [$];
    table_row_t    directed_rows [$];
    int            mismatch_count = 0;
    bit            send_steady = 1'b0;
    bit            sink_steady = 1'b0;

    swept_box_reservation_table #(
        .TABLE_SLOTS(SLOTS),
        .COORD_BITS (COORD_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Works out the result of one request and updates the shadow table.
    function automatic slot_outcome_t arbitrate_request(box_req_t r);
        logic signed [COORD_W:0] qlo [3];
        logic signed [COORD_W:0] qhi [3];
        logic signed [COORD_W:0] a, b, m;
        int            free_idx;
        bit            hit, axis_hit;
        slot_outcome_t res;
        res.slot = '0;
        if (r.kind == REQ_RELEASE) begin
            if (r.rel_slot >= 1 && r.rel_slot <= SLOTS) begin
                occupied[r.rel_slot - 1] = 1'b0;
                res.slot = r.rel_slot;
            end
            res.outcome = OUT_RELEASED;
            return res;
        end
        m = $signed({2'b00, r.margin});
        for (int k = 0; k < 3; k++) begin
            a = $signed(r.first_pt[k]);
            b = $signed(r.second_pt[k]);
            qlo[k] = ((a <= b) ? a : b) - m;
            qhi[k] = ((a <= b) ? b : a) + m;
        end
        hit = 1'b0;
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (occupied[i]) begin
                axis_hit = 1'b1;
                for (int k = 0; k < 3; k++)
                    if (!(hi_bound[i][k] > qlo[k] && qhi[k] > lo_bound[i][k]))
                        axis_hit = 1'b0;
                if (axis_hit)
                    hit = 1'b1;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit) begin
            res.outcome = OUT_OVERLAP;
        end else if (free_idx < 0) begin
            res.outcome = OUT_FULL;
        end else begin
            occupied[free_idx] = 1'b1;
            for (int k = 0; k < 3; k++) begin
                lo_bound[free_idx][k] = qlo[k];
                hi_bound[free_idx][k] = qhi[k];
            end
            res.slot = SLOT_W'(free_idx + 1);
            res.outcome = OUT_GRANTED;
        end
        return res;
    endfunction

    // release_slot is don't-care on a reserve, so it gets noise
    function automatic box_req_t box_req(int x0, int y0, int z0, int x1, int y1, int z1, int m);
        box_req_t r;
        r.kind = REQ_RESERVE;
        r.first_pt[0] = COORD_W'(x0);
        r.first_pt[1] = COORD_W'(y0);
        r.first_pt[2] = COORD_W'(z0);
        r.second_pt[0] = COORD_W'(x1);
        r.second_pt[1] = COORD_W'(y1);
        r.second_pt[2] = COORD_W'(z1);
        r.margin = (COORD_W-1)'(m);
        r.rel_slot = SLOT_W'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic box_req_t release_req(int slot);
        box_req_t r;
        r.kind = REQ_RELEASE;
        for (int k = 0; k < 3; k++) begin
            r.first_pt[k] = COORD_W'($urandom());
            r.second_pt[k] = COORD_W'($urandom());
        end
        r.margin = (COORD_W-1)'($urandom());
        r.rel_slot = SLOT_W'(slot);
        return r;
    endfunction

    function automatic void add_row(box_req_t r, bit known, int slot, outcome_t oc);
        table_row_t row;
        row.req = r;
        row.known = known;
        row.want.slot = SLOT_W'(slot);
        row.want.outcome = oc;
        directed_rows.push_back(row);
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic box_req_t rand_request();
        int pick, cx, cy, cz, x0, y0, z0;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 9) < 8)
                return release_req($urandom_range(1, SLOTS));
            return release_req($urandom_range(0, 31));
        end
        if (pick < 75) begin
            if ($urandom_range(0, 1) == 1) begin
                // unit cells on a coarse grid: neighbors touch exactly
                cx = $urandom_range(0, 7) * 64 - 256;
                cy = $urandom_range(0, 7) * 64 - 256;
                cz = $urandom_range(0, 7) * 64 - 256;
                if ($urandom_range(0, 1) == 1)
                    return box_req(cx + 64, cy + 64, cz + 64, cx, cy, cz, 0);
                return box_req(cx, cy, cz, cx + 64, cy + 64, cz + 64, 0);
            end
            x0 = $urandom_range(0, 600) - 300;
            y0 = $urandom_range(0, 600) - 300;
            z0 = $urandom_range(0, 600) - 300;
            return box_req(x0, y0, z0,
                           x0 + $urandom_range(0, 120) - 60,
                           y0 + $urandom_range(0, 120) - 60,
                           z0 + $urandom_range(0, 120) - 60,
                           $urandom_range(0, 40));
        end
        if (pick < 92)
            return box_req($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom_range(0, 255));
        return box_req($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom_range(0, 8388607));
    endfunction

    task automatic send_request(box_req_t r);
        int gap;
        gap = send_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {{(TDATA_W - REQ_W){1'b0}}, r.rel_slot, r.margin,
                          r.second_pt, r.first_pt};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    initial begin
        slot_outcome_t got;
        // out-of-range and free-slot releases
        add_row(release_req(0), 1, 0, OUT_RELEASED);
        add_row(release_req(SLOTS + 1), 1, 0, OUT_RELEASED);
        add_row(release_req(31), 1, 0, OUT_RELEASED);
        add_row(release_req(5), 1, 5, OUT_RELEASED);
        // widest possible box, then a point in its corner
        add_row(box_req(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 8388607),
                1, 1, OUT_GRANTED);
        add_row(box_req(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 0),
                1, 0, OUT_OVERLAP);
        add_row(release_req(1), 1, 1, OUT_RELEASED);
        add_row(box_req(0, 0, 0, 256, 256, 256, 0), 0, 0, OUT_GRANTED);
        // face contact only
        add_row(box_req(256, 0, 0, 512, 256, 256, 0), 0, 0, OUT_GRANTED);
        // points swapped, margin reaches into the previous box
        add_row(box_req(700, 0, 0, 600, 256, 256, 100), 0, 0, OUT_GRANTED);
        // degenerate box on a corner
        add_row(box_req(0, 0, 0, 0, 0, 0, 0), 0, 0, OUT_GRANTED);
        for (int i = 1; i <= 13; i++)
            add_row(box_req(4096 * i, 0, 0, 4096 * i + 100, 100, 100, 0), 0, 0, OUT_GRANTED);
        add_row(box_req(-100000, -100000, -100000, -99000, -99000, -99000, 0),
                1, 0, OUT_FULL);
        // full table, but overlap wins
        add_row(box_req(10, 10, 10, 20, 20, 20, 0), 1, 0, OUT_OVERLAP);
        add_row(release_req(SLOTS), 1, SLOTS, OUT_RELEASED);
        add_row(box_req(-100000, -100000, -100000, -99000, -99000, -99000, 0),
                0, 0, OUT_GRANTED);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req);
            got = arbitrate_request(directed_rows[i].req);
            pending_outcomes.push_back(directed_rows[i].known ? directed_rows[i].want : got);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            box_req_t r;
            if (n % 150 == 0)
                send_steady = ($urandom_range(0, 3) == 0);
            r = rand_request();
            send_request(r);
            pending_outcomes.push_back(arbitrate_request(r));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 500 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!sink_steady)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        slot_outcome_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with no request pending, slot %0d outcome %0d",
                         $realtime, m_axis_tdata[SLOT_W-1:0], m_axis_tuser);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_axis_tdata[SLOT_W-1:0] !== want.slot) begin
                    $display("%0t: slot_number expected %0d got %0d",
                             $realtime, want.slot, m_axis_tdata[SLOT_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.outcome) begin
                    $display("%0t: outcome expected %0d got %0d",
                             $realtime, want.outcome, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
